// File: rtl/elu_pkg.sv
`timescale 1ns / 1ps
// elu_pkg: shared types, constants and the exponential tables of the ELU/SELU core.
// Depends on nothing; every other file of the block uses it by scoped names.
package elu_pkg;

    // Exponential table resolution: 2^EXP_TABLE_BITS steps per unit of -x
    localparam int unsigned EXP_TABLE_BITS = 8;
    localparam int unsigned TSIZE          = (1 << EXP_TABLE_BITS) + 1;

    // Q0.32 one, and the magnitude beyond which exp(x) flushes to zero (-16 in Q8.8)
    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [16:0] M_LIMIT  = 17'd4096;

    // Saturation bounds of the Q8.8 result
    localparam logic [16:0] MAG_LIMIT = 17'd32768;
    localparam logic [19:0] POS_LIMIT = 20'd32767;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELU   = 2'd2;

    localparam logic [15:0] ALPHA_RESET  = 16'd4096;
    localparam logic [15:0] LAMBDA_RESET = 16'd4096;

    // Payload of one input beat
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in;
    } t_elu_in;

    // Payload of one result beat
    typedef struct packed {
        logic signed [15:0] activation;
        logic               last_out;
        logic               saturated;
    } t_elu_out;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] lambda;
        logic        selu;
    } t_elu_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic               neg;        // sample below zero
        logic signed [15:0] sample;
        logic [32:0]        e_scale;    // exp(-integer part), zero past the flush point
        logic [32:0]        frac_val;   // exp(-fraction part)
        logic               last;
    } t_elu_cmd;

    typedef logic [255:0][32:0] t_frac_tab;
    typedef logic [16:0][32:0]  t_exp_tab;

    // Integer divide by a small loop count, one literal divisor per arm
    function automatic logic [63:0] div_by_k(logic [63:0] a, int unsigned k);
        logic [63:0] q;
        q = a;
        unique case (k)
            1:  q = a / 1;
            2:  q = a / 2;
            3:  q = a / 3;
            4:  q = a / 4;
            5:  q = a / 5;
            6:  q = a / 6;
            7:  q = a / 7;
            8:  q = a / 8;
            9:  q = a / 9;
            10: q = a / 10;
            11: q = a / 11;
            12: q = a / 12;
            13: q = a / 13;
            14: q = a / 14;
            15: q = a / 15;
            16: q = a / 16;
            17: q = a / 17;
            18: q = a / 18;
            19: q = a / 19;
            20: q = a / 20;
            default: q = a;
        endcase
        return q;
    endfunction

    // exp(-num / 2^EXP_TABLE_BITS) in Q0.32 from a 20-term series
    function automatic logic [32:0] exp_neg_frac(int unsigned num);
        logic signed [64:0] sum;
        logic [63:0]        term;
        sum  = 65'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int unsigned k = 1; k <= 20; k++) begin
            // floor(a / (k*2^B)) taken as floor(floor(a / 2^B) / k)
            term = div_by_k((term * 64'(num)) >> EXP_TABLE_BITS, k);
            if (k[0]) begin
                sum = sum - $signed({1'b0, term});
            end else begin
                sum = sum + $signed({1'b0, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({32'd0, ONE_Q32})) begin
            sum = $signed({32'd0, ONE_Q32});
        end
        return sum[32:0];
    endfunction

    // exp of minus the fractional part, indexed by the low byte of -x, interpolated
    function automatic t_frac_tab build_frac_tab();
        t_frac_tab   tab;
        int unsigned p;
        int unsigned idx;
        int unsigned rem;
        logic [32:0] ti;
        logic [32:0] ti1;
        logic [63:0] dif;
        tab = '0;
        for (int unsigned fr = 0; fr < 256; fr++) begin
            p   = fr << EXP_TABLE_BITS;
            idx = p >> 8;
            rem = p & 255;
            if (idx > TSIZE - 2) begin
                idx = TSIZE - 2;
            end
            ti      = exp_neg_frac(idx);
            ti1     = exp_neg_frac(idx + 1);
            dif     = (64'(ti - ti1) * 64'(rem)) >> 8;
            tab[fr] = ti - dif[32:0];
        end
        return tab;
    endfunction

    // exp(-n) in Q0.32 for n = 0..16, rounded product chain
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [32:0] tl;
        logic [63:0] acc;
        tab    = '0;
        tl     = exp_neg_frac(TSIZE - 1);
        tab[0] = ONE_Q32;
        for (int unsigned n = 1; n < 17; n++) begin
            acc    = (64'(tab[n-1]) * 64'(tl) + 64'h8000_0000) >> 32;
            tab[n] = acc[32:0];
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();
    localparam t_exp_tab  EXP_TAB  = build_exp_tab();

endpackage

// File: rtl/elu_selu_activation_core.sv
`timescale 1ns / 1ps
// elu_selu_activation_core: top level of the ELU/SELU stream core and its register bank.
// Depends on elu_pkg, elu_front, elu_queue and elu_back.
//
// Streams signed Q8.8 activations, one beat per clock while the output is not stalled, one result per
// input in input order. Zero and positive samples pass through (scaled by lambda in SELU
// mode); negative samples give alpha*(exp(x)-1), optionally times lambda, with exp taken
// from constant tables and flushed to zero below -16. Results saturate to Q8.8 and flag
// it. An accepted beat is written into the command queue at its accepting edge, then is
// popped into the exp product stage, passes the alpha stage and is lambda-scaled into
// the output register that drives o_valid. A four-entry queue parts the front from the
// back, so input keeps flowing for a few beats while the output is stalled. Registers:
// index 0 alpha (Q4.12), index 1 lambda (Q4.12), index 2 SELU enable; other indexes are
// ignored. Write them only while idle.
module elu_selu_activation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  elu_pkg::t_elu_in                  i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output elu_pkg::t_elu_out                 o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [elu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    elu_pkg::t_elu_cfg r_cfg;
    elu_pkg::t_elu_cmd push_cmd;
    elu_pkg::t_elu_cmd head_cmd;
    logic              push;
    logic              full;
    logic              empty;
    logic              pop;

    // Register bank, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha  <= elu_pkg::ALPHA_RESET;
            r_cfg.lambda <= elu_pkg::LAMBDA_RESET;
            r_cfg.selu   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                elu_pkg::CFG_ALPHA:  r_cfg.alpha  <= i_cfg_data;
                elu_pkg::CFG_LAMBDA: r_cfg.lambda <= i_cfg_data;
                elu_pkg::CFG_SELU:   r_cfg.selu   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    elu_front u_front (
        .i_in    (i_in),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    elu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (full),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_head      (head_cmd)
    );

    elu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_out       (o_out),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

endmodule

// File: rtl/elu_front.sv
`timescale 1ns / 1ps
// elu_front: accepts input beats, classifies the sign and looks up the exponential factors.
// Depends on elu_pkg; pushes one command per accepted beat into elu_queue.
module elu_front (
    input  elu_pkg::t_elu_in   i_in,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_full,
    output logic               o_push,
    output elu_pkg::t_elu_cmd  o_cmd
);

    logic        neg;
    logic [16:0] m;
    logic        over;
    logic [4:0]  ip_sel;
    logic [7:0]  frac;

    // Stall only on a full queue
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Magnitude of a negative sample, split into integer and fraction
    always_comb begin
        neg    = i_in.sample[15];
        m      = 17'd0 - {i_in.sample[15], i_in.sample};
        over   = m > elu_pkg::M_LIMIT;
        ip_sel = over ? 5'd0 : m[12:8];
        frac   = m[7:0];
    end

    // Command for the back end
    always_comb begin
        o_cmd.neg      = neg;
        o_cmd.sample   = i_in.sample;
        o_cmd.e_scale  = over ? 33'd0 : elu_pkg::EXP_TAB[ip_sel];
        o_cmd.frac_val = elu_pkg::FRAC_TAB[frac];
        o_cmd.last     = i_in.last_in;
    end

endmodule

// File: rtl/elu_queue.sv
`timescale 1ns / 1ps
// elu_queue: short FIFO of classified commands between front and back.
// Depends on elu_pkg for the command type and the depth.
module elu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  elu_pkg::t_elu_cmd  i_push_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output elu_pkg::t_elu_cmd  o_head
);

    localparam logic [elu_pkg::QUEUE_AW:0] DEPTH_CNT = (elu_pkg::QUEUE_AW + 1)'(elu_pkg::QUEUE_DEPTH);

    elu_pkg::t_elu_cmd               r_mem [elu_pkg::QUEUE_DEPTH];
    logic [elu_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [elu_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [elu_pkg::QUEUE_AW:0]      r_count;
    logic [elu_pkg::QUEUE_AW:0]      n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = r_count == DEPTH_CNT;
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/elu_back.sv
`timescale 1ns / 1ps
// elu_back: three-stage arithmetic pipeline (exp product, alpha scale, lambda scale and
// saturation) ending in the output register. Depends on elu_pkg.
module elu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  elu_pkg::t_elu_cfg  i_cfg,
    input  logic               i_cmd_valid,
    input  elu_pkg::t_elu_cmd  i_cmd,
    output logic               o_cmd_pop,
    output elu_pkg::t_elu_out  o_out,
    output logic               o_valid,
    input  logic               i_stall
);

    logic        advance;

    // Stage 1: exp(x) and the positive-side product
    logic        r_v1;
    logic        r1_neg;
    logic [15:0] r1_x;
    logic [32:0] r1_e;
    logic [30:0] r1_pos;
    logic        r1_last;
    logic [65:0] n_prod;
    logic [30:0] n_pos;

    // Stage 2: v = alpha * (1 - exp(x)), rounded positive result
    logic        r_v2;
    logic        r2_neg;
    logic [15:0] r2_x;
    logic [23:0] r2_v;
    logic [19:0] r2_pos;
    logic        r2_last;
    logic [32:0] n_d;
    logic [47:0] n_ad;
    logic [31:0] n_pos_rnd;

    // Stage 3: output register
    logic              r_out_valid;
    elu_pkg::t_elu_out r_out;
    elu_pkg::t_elu_out n_out;
    logic [40:0]       n_vl;
    logic [24:0]       n_ve;
    logic [16:0]       n_mag;
    logic              n_sat;

    // Whole pipeline moves unless a finished result is held
    assign advance   = !r_out_valid || !i_stall;
    assign o_cmd_pop = advance && i_cmd_valid;
    assign o_out     = r_out;
    assign o_valid   = r_out_valid;

    always_comb begin
        n_prod = 66'(i_cmd.e_scale) * 66'(i_cmd.frac_val);
        n_pos  = 31'(i_cmd.sample[14:0]) * 31'(i_cfg.lambda);
    end

    always_comb begin
        n_d       = elu_pkg::ONE_Q32 - r1_e;
        n_ad      = 48'(i_cfg.alpha) * 48'(n_d) + 48'h80_0000;
        n_pos_rnd = 32'(r1_pos) + 32'd2048;
    end

    // Final scale, sign and saturation
    always_comb begin
        n_vl  = 41'(r2_v) * 41'(i_cfg.lambda) + 41'h80_0000;
        n_ve  = 25'(r2_v) + 25'd2048;
        n_mag = '0;
        n_sat = 1'b0;
        n_out.last_out = r2_last;
        if (r2_neg) begin
            n_mag = i_cfg.selu ? n_vl[40:24] : 17'(n_ve[24:12]);
            if (n_mag > elu_pkg::MAG_LIMIT) begin
                n_mag = elu_pkg::MAG_LIMIT;
                n_sat = 1'b1;
            end
            n_out.activation = $signed(16'(17'd0 - n_mag));
        end else if (i_cfg.selu) begin
            if (r2_pos > elu_pkg::POS_LIMIT) begin
                n_sat            = 1'b1;
                n_out.activation = $signed(elu_pkg::POS_LIMIT[15:0]);
            end else begin
                n_out.activation = $signed(r2_pos[15:0]);
            end
        end else begin
            n_out.activation = $signed(r2_x);
        end
        n_out.saturated = n_sat;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= i_cmd_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_neg  <= i_cmd.neg;
            r1_x    <= i_cmd.sample;
            r1_e    <= n_prod[64:32];
            r1_pos  <= n_pos;
            r1_last <= i_cmd.last;

            r2_neg  <= r1_neg;
            r2_x    <= r1_x;
            r2_v    <= n_ad[47:24];
            r2_pos  <= n_pos_rnd[31:12];
            r2_last <= r1_last;

            r_out   <= n_out;
        end
    end

endmodule

// File: sim/elu_selu_activation_core_tb.sv
`timescale 1ns / 1ps
// elu_selu_activation_core_tb: self-checking bench for the ELU/SELU stream core.
// Depends on elu_pkg and elu_selu_activation_core; predicts every result bit-exact and
// checks it in order under random idling, back pressure and several register settings.
module elu_selu_activation_core_tb;

    typedef longint unsigned u64_t;

    // Exponential table geometry and fixed-point anchors
    localparam int unsigned TAB_BITS = elu_pkg::EXP_TABLE_BITS;
    localparam int unsigned TAB_N    = 1 << TAB_BITS;
    localparam u64_t        ONE_Q32  = 64'h1_0000_0000;
    localparam u64_t        HALF_Q32 = 64'h8000_0000;
    localparam u64_t        HALF_Q24 = 64'h80_0000;

    localparam logic MODE_ELU  = 1'b0;
    localparam logic MODE_SELU = 1'b1;

    // Index that maps to no register; writes to it must be dropped
    localparam logic [elu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    elu_pkg::t_elu_in                  i_in;
    logic                              o_valid;
    logic                              i_stall;
    elu_pkg::t_elu_out                 o_out;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [elu_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [15:0]                       i_cfg_data;

    // Shadow copy of the register bank
    logic [15:0] cfg_alpha;
    logic [15:0] cfg_lambda;
    logic        cfg_selu;

    // exp(-i/2^TAB_BITS) and exp(-n), both Q0.32
    u64_t exp_frac_q32 [0:TAB_N];
    u64_t exp_int_q32  [0:16];

    elu_pkg::t_elu_out expected_activations [$];

    bit tx_quiet;
    bit rx_quiet;
    int hold_req;
    int hold_left;
    int idle_cycles;
    int errors;
    int beats_sent;
    int results_checked;
    int saturations_seen;
    int reg_writes;
    int input_held_cycles;

    elu_selu_activation_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Exponential tables: truncated 20-term series, then a rounded product chain
    initial begin : build_exp_tables
        longint series;
        u64_t   term;
        for (int i = 0; i <= TAB_N; i++) begin
            series = $signed(ONE_Q32);
            term   = ONE_Q32;
            for (int k = 1; k <= 20; k++) begin
                term = (term * u64_t'(i)) / (u64_t'(k) << TAB_BITS);
                if (k % 2 == 1) begin
                    series -= $signed(term);
                end else begin
                    series += $signed(term);
                end
            end
            if (series < 0) begin
                series = 0;
            end
            if (series > $signed(ONE_Q32)) begin
                series = $signed(ONE_Q32);
            end
            exp_frac_q32[i] = u64_t'(series);
        end
        exp_int_q32[0] = ONE_Q32;
        for (int n = 1; n <= 16; n++) begin
            exp_int_q32[n] = (exp_int_q32[n-1] * exp_frac_q32[TAB_N] + HALF_Q32) >> 32;
        end
    end

    // ELU/SELU of one sample under the current shadow registers
    function automatic elu_pkg::t_elu_out predict_activation(elu_pkg::t_elu_in beat);
        elu_pkg::t_elu_out r;
        int                x;
        int unsigned       m;
        int unsigned       ip;
        int unsigned       idx;
        int unsigned       rem;
        u64_t              p;
        u64_t              f;
        u64_t              e;
        u64_t              v;
        u64_t              mag;
        u64_t              pr;
        r.last_out  = beat.last_in;
        r.saturated = 1'b0;
        x = $signed(beat.sample);
        if (x >= 0) begin
            if (cfg_selu == MODE_SELU) begin
                pr = (u64_t'(x) * u64_t'(cfg_lambda) + 64'd2048) >> 12;
                if (pr > 64'd32767) begin
                    pr          = 64'd32767;
                    r.saturated = 1'b1;
                end
                r.activation = pr[15:0];
            end else begin
                r.activation = beat.sample;
            end
        end else begin
            m = -x;
            if (m > 4096) begin
                e = 0;                      // below minus sixteen exp flushes to zero
            end else begin
                ip  = m >> 8;
                p   = u64_t'(m & 255) << TAB_BITS;
                idx = 32'(p >> 8);
                rem = 32'(p & 255);
                if (idx > TAB_N - 1) begin
                    idx = TAB_N - 1;
                end
                f = exp_frac_q32[idx]
                    - (((exp_frac_q32[idx] - exp_frac_q32[idx+1]) * u64_t'(rem)) >> 8);
                e = (ip == 0) ? f : (exp_int_q32[ip] * f) >> 32;
            end
            v = (u64_t'(cfg_alpha) * (ONE_Q32 - e) + HALF_Q24) >> 24;
            if (cfg_selu == MODE_SELU) begin
                mag = (v * u64_t'(cfg_lambda) + HALF_Q24) >> 24;
            end else begin
                mag = (v + 64'd2048) >> 12;
            end
            if (mag > 64'd32768) begin
                mag         = 64'd32768;
                r.saturated = 1'b1;
            end
            pr           = 64'd0 - mag;
            r.activation = pr[15:0];
        end
        return r;
    endfunction

    // Mostly negative samples, clustered near zero and around the flush point
    function automatic logic [15:0] random_sample();
        logic [15:0] s;
        case ($urandom_range(0, 6))
            0, 1:    s = 16'($urandom);
            2:       s = 16'(0 - int'($urandom_range(1, 512)));
            3:       s = 16'(0 - int'($urandom_range(3900, 4300)));
            4:       s = 16'(0 - int'($urandom_range(4097, 32768)));
            5:       s = 16'($urandom_range(0, 32767));
            default: s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] pick_scale();
        logic [15:0] s;
        case ($urandom_range(0, 4))
            0:       s = 16'h0000;
            1:       s = 16'hFFFF;
            2:       s = 16'd4096;
            3:       s = 16'($urandom_range(0, 8191));
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // Offer one beat, maybe after a one-cycle gap; valid is left high for the next call
    task automatic send_beat(input logic [15:0] sample, input logic last);
        elu_pkg::t_elu_in beat;
        beat.sample  = sample;
        beat.last_in = last;
        if (!tx_quiet && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_activations.push_back(predict_activation(beat));
        beats_sent++;
    endtask

    // Stop offering and wait until every expected result is back and the pipe is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_activations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [elu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            elu_pkg::CFG_ALPHA:  cfg_alpha  = data;
            elu_pkg::CFG_LAMBDA: cfg_lambda = data;
            elu_pkg::CFG_SELU:   cfg_selu   = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [15:0] alpha, input logic [15:0] lambda,
                              input logic mode);
        wait_drained();
        write_reg(elu_pkg::CFG_ALPHA, alpha);
        write_reg(elu_pkg::CFG_LAMBDA, lambda);
        write_reg(elu_pkg::CFG_SELU, {15'($urandom), mode});
    endtask

    // Reset values: unit alpha and lambda, plain ELU; field extremes and flush edge
    task automatic test_reset_defaults();
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0001, 1'b1);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'hFF00, 1'b0);
        send_beat(16'hF000, 1'b0);      // exactly minus sixteen
        send_beat(16'hEFFF, 1'b1);      // just past the flush point
        send_beat(16'h8000, 1'b0);
        send_beat(16'hFF80, 1'b0);
        send_beat(16'h00FF, 1'b1);
    endtask

    // Full-scale alpha and lambda in SELU: saturation on both sides
    task automatic test_selu_extremes();
        set_config(16'hFFFF, 16'hFFFF, MODE_SELU);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'h0000, 1'b1);
        send_beat(16'h8000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'hFF00, 1'b1);
    endtask

    // Zero scales give zero results bar ELU pass-through; unused-index writes change nothing
    task automatic test_zero_scales();
        set_config(16'h0000, 16'h0000, MODE_SELU);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b1);
        send_beat(16'hFED4, 1'b0);
        send_beat(16'h0005, 1'b0);
        set_config(16'h0000, 16'd4096, MODE_ELU);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0100, 1'b1);
        wait_drained();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_beat(16'hFF00, 1'b1);
    endtask

    // Several settings, two fixed and the rest random, one of them with no idling on either side
    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       set_config(16'hFFFF, 16'hFFFF, MODE_SELU);
                1:       set_config(16'hFFFF, 16'h0000, MODE_ELU);
                default: set_config(pick_scale(), pick_scale(), 1'($urandom_range(0, 1)));
            endcase
            if (ph % 3 == 2) begin
                write_reg(CFG_UNUSED, 16'($urandom));
            end
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3);
            repeat (180) send_beat(random_sample(), $urandom_range(0, 15) == 0);
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    // Receiver holds off while beats keep coming, so the core must stall its input
    task automatic test_input_backpressure();
        wait_drained();
        tx_quiet = 1;
        hold_req = 80;
        repeat (48) send_beat(random_sample(), $urandom_range(0, 15) == 0);
        tx_quiet = 0;
    endtask

    // Sender goes quiet until everything is back, then resumes
    task automatic test_sender_pause();
        repeat (30) send_beat(random_sample(), $urandom_range(0, 15) == 0);
        wait_drained();
        repeat (30) send_beat(random_sample(), $urandom_range(0, 15) == 0);
    endtask

    // Result-side stall: random, quiet, or a long counted hold
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 7);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        elu_pkg::t_elu_out want;
        if (o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_activations.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, o_out);
                errors++;
            end else begin
                want = expected_activations.pop_front();
                if (o_out.activation !== want.activation) begin
                    $display("%0t ns: activation mismatch, expected %h, actual %h",
                             $time, want.activation, o_out.activation);
                    errors++;
                end
                if (o_out.last_out !== want.last_out) begin
                    $display("%0t ns: last_out mismatch, expected %b, actual %b",
                             $time, want.last_out, o_out.last_out);
                    errors++;
                end
                if (o_out.saturated !== want.saturated) begin
                    $display("%0t ns: saturated mismatch, expected %b, actual %b",
                             $time, want.saturated, o_out.saturated);
                    errors++;
                end
                results_checked++;
                if (want.saturated) begin
                    saturations_seen++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)
            || (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_valid === 1'b1 && o_stall === 1'b1) begin
            input_held_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, expected_activations.size());
            $display("elu_selu_activation_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = elu_pkg::CFG_ALPHA;
        i_cfg_data  = '0;
        cfg_alpha   = 16'd4096;
        cfg_lambda  = 16'd4096;
        cfg_selu    = MODE_ELU;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_selu_extremes();
        test_zero_scales();
        test_random_phases();
        test_input_backpressure();
        test_sender_pause();
        wait_drained();

        $display("Covered %0d beats under %0d register writes (ELU/SELU, zero to full scale);",
                 beats_sent, reg_writes);
        $display("%0d results checked, %0d saturated, input held off for %0d cycles.",
                 results_checked, saturations_seen, input_held_cycles);
        if (errors == 0) begin
            $display("elu_selu_activation_core_tb: PASS");
        end else begin
            $display("elu_selu_activation_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/elu_pkg.sv
rtl/elu_front.sv
rtl/elu_queue.sv
rtl/elu_back.sv
rtl/elu_selu_activation_core.sv
sim/elu_selu_activation_core_tb.sv
